// File: design/tcd_pkg.sv
`timescale 1ns / 1ps
package tcd_pkg;

  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 52;
  localparam int MSG_TOK_W  = 8;
  localparam int SRC_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    CMD_FETCH      = 2'd0,
    CMD_ACQUIRE    = 2'd1,
    CMD_EVICT      = 2'd2,
    CMD_LOCAL_NOTE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DEST_UPPER    = 2'd0,
    DEST_LOWER    = 2'd1,
    DEST_CONSUMED = 2'd2
  } dest_e;

  typedef enum logic [1:0] {
    CFG_FIRST_CACHE = 2'd0,
    CFG_GROUP_SIZE  = 2'd1,
    CFG_LINE_LOG2   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic                 from_upper;
    logic [ADDR_W-1:0]    address;
    logic [MSG_TOK_W-1:0] token_count;
    logic                 is_transient;
    logic [SRC_W-1:0]     source_cache;
    logic                 ignore_in;
    logic                 upper_has_room;
  } msg_t;

  typedef struct packed {
    logic [1:0]           destination;
    logic [1:0]           out_type;
    logic [ADDR_W-1:0]    out_address;
    logic [MSG_TOK_W-1:0] out_tokens;
    logic                 out_transient;
    logic [SRC_W-1:0]     out_source;
    logic                 out_ignore;
    logic                 fault;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic commit;
    logic clear;
  } ctrl_t;

endpackage

// File: design/tcd_intf.sv
`timescale 1ns / 1ps
interface tcd_msg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        from_upper;
  logic [63:0] address;
  logic [7:0]  token_count;
  logic        is_transient;
  logic [7:0]  source_cache;
  logic        ignore_in;
  logic        upper_has_room;

  modport source (output valid, cmd, from_upper, address, token_count, is_transient,
                  source_cache, ignore_in, upper_has_room, input ready);
  modport sink (input valid, cmd, from_upper, address, token_count, is_transient,
                source_cache, ignore_in, upper_has_room, output ready);
endinterface

interface tcd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  destination;
  logic [1:0]  out_type;
  logic [63:0] out_address;
  logic [7:0]  out_tokens;
  logic        out_transient;
  logic [7:0]  out_source;
  logic        out_ignore;
  logic        fault;

  modport source (output valid, destination, out_type, out_address, out_tokens,
                  out_transient, out_source, out_ignore, fault, input ready);
  modport sink (input valid, destination, out_type, out_address, out_tokens,
                out_transient, out_source, out_ignore, fault, output ready);
endinterface

interface tcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/tcd_ctrl.sv
`timescale 1ns / 1ps
module tcd_ctrl #(
  parameter int NUM_SETS = 64,
  parameter int SET_IW   = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcd_pkg::ctrl_t    ctrl_o,
  output logic [SET_IW-1:0] clr_addr_o
);
  import tcd_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q;
  logic [SET_IW-1:0] clr_q;
  logic              out_valid_q;
  logic              out_free;

  always_comb begin
    out_free      = !out_valid_q || out_ready_i;
    in_ready_o    = (state_q == ST_IDLE);
    ctrl_o.rd_en  = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.commit = (state_q == ST_EXEC) && out_free;
    ctrl_o.clear  = (state_q == ST_CLEAR);
  end

  assign out_valid_o = out_valid_q;
  assign clr_addr_o  = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (clr_q == SET_IW'(NUM_SETS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (ctrl_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: design/tcd_datapath.sv
`timescale 1ns / 1ps
module tcd_datapath #(
  parameter int NUM_SETS   = 64,
  parameter int NUM_WAYS   = 16,
  parameter int TOKEN_BITS = 8,
  parameter int SET_IW     = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcd_pkg::ctrl_t               ctrl_i,
  input  logic [SET_IW-1:0]            clr_addr_i,
  input  tcd_pkg::msg_t                msg_i,
  input  logic                         cfg_we_i,
  input  logic [tcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tcd_pkg::res_t                res_o
);
  import tcd_pkg::*;

  localparam int SET_SH = $clog2(NUM_SETS);
  localparam int WAY_IW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int EW     = 1 + TAG_W + TOKEN_BITS;
  localparam int ROW_W  = NUM_WAYS * EW;
  localparam int SUM_W  = ((TOKEN_BITS > MSG_TOK_W) ? TOKEN_BITS : MSG_TOK_W) + 1;
  localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = {TOKEN_BITS{1'b1}};

  function automatic logic [TOKEN_BITS-1:0] sat_add(logic [TOKEN_BITS-1:0] a,
                                                    logic [MSG_TOK_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(TOKEN_MAX)) ? TOKEN_MAX : s[TOKEN_BITS-1:0];
  endfunction

  // Configuration registers.
  logic [7:0] first_q;
  logic [4:0] cig_q;
  logic [3:0] lsl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 8'd0;
      cig_q   <= 5'd4;
      lsl_q   <= 4'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_CACHE: first_q <= cfg_data_i;
        CFG_GROUP_SIZE:  cig_q   <= cfg_data_i[4:0];
        CFG_LINE_LOG2:   lsl_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Address split at accept time.
  logic [ADDR_W-1:0] line;
  logic [ADDR_W-1:0] tag_full;
  logic [SET_IW-1:0] set_in;

  always_comb begin
    line     = msg_i.address >> lsl_q;
    tag_full = line >> SET_SH;
    set_in   = (NUM_SETS > 1) ? line[SET_IW-1:0] : '0;
  end

  msg_t              req_q;
  logic [SET_IW-1:0] set_q;
  logic [TAG_W-1:0]  tag_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      req_q <= msg_i;
      set_q <= set_in;
      tag_q <= tag_full[TAG_W-1:0];
    end
  end

  // One row per set holds every way: valid, tag and token count.
  logic [ROW_W-1:0]  mem [NUM_SETS];
  logic [ROW_W-1:0]  rdata_q;
  logic [ROW_W-1:0]  wdata;
  logic [ROW_W-1:0]  new_row;
  logic [SET_IW-1:0] waddr;
  logic              we;
  logic              upd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[set_in];
    end
  end

  assign waddr = ctrl_i.clear ? clr_addr_i : set_q;
  assign wdata = ctrl_i.clear ? '0 : new_row;
  assign we    = ctrl_i.clear || (ctrl_i.commit && upd);

  // Lookup and decision.
  logic [NUM_WAYS-1:0]   hit_vec;
  logic [NUM_WAYS-1:0]   free_vec;
  logic [WAY_IW-1:0]     hit_idx;
  logic [WAY_IW-1:0]     free_idx;
  logic [WAY_IW-1:0]     sel;
  logic                  hit;
  logic                  grp;
  logic [8:0]            diff;
  logic                  perm;
  logic                  alloc;
  logic                  known;
  logic                  f;
  logic [1:0]            dest;
  logic                  oign;
  logic [TOKEN_BITS-1:0] old_tok;
  logic [TOKEN_BITS-1:0] base_tok;
  logic [TOKEN_BITS-1:0] new_tok;
  logic                  new_valid;
  logic [EW-1:0]         way_word;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_word    = rdata_q[w*EW +: EW];
      hit_vec[w]  = way_word[EW-1] && (way_word[EW-2:TOKEN_BITS] == tag_q);
      free_vec[w] = !way_word[EW-1];
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_idx = WAY_IW'(w);
      if (free_vec[w]) free_idx = WAY_IW'(w);
    end
    hit = |hit_vec;

    diff = {1'b0, req_q.source_cache} - {1'b0, first_q};
    grp  = !diff[8] && (diff[7:0] < {3'b000, cig_q});
    perm = (req_q.token_count != '0) && !req_q.is_transient;

    way_word = rdata_q[hit_idx*EW +: EW];
    old_tok  = way_word[TOKEN_BITS-1:0];

    f         = 1'b0;
    alloc     = 1'b0;
    known     = 1'b0;
    upd       = 1'b0;
    new_valid = 1'b1;
    new_tok   = old_tok;
    base_tok  = old_tok;
    dest      = DEST_CONSUMED;
    oign      = req_q.ignore_in;

    if (!req_q.from_upper) begin
      if (req_q.ignore_in) begin
        dest = DEST_UPPER;
        oign = 1'b0;
      end else if (req_q.cmd == CMD_LOCAL_NOTE) begin
        if (!hit) begin
          f = 1'b1;
        end else begin
          new_tok = sat_add(old_tok, req_q.token_count);
          upd     = 1'b1;
          oign    = 1'b0;
        end
      end else begin
        if (req_q.cmd == CMD_FETCH && req_q.is_transient) f = 1'b1;
        if (req_q.cmd == CMD_EVICT && (req_q.token_count == '0 ||
            req_q.is_transient || !grp)) f = 1'b1;
        if (!f && perm && !hit) f = 1'b1;
        if (!f) begin
          if (perm) begin
            // The count stops at zero and an empty line is dropped.
            if (SUM_W'(req_q.token_count) >= SUM_W'(old_tok)) begin
              new_tok = '0;
            end else begin
              new_tok = old_tok - TOKEN_BITS'(req_q.token_count);
            end
            new_valid = (new_tok != '0);
            upd       = 1'b1;
          end
          dest = DEST_UPPER;
          oign = 1'b0;
        end
      end
    end else begin
      if (req_q.cmd == CMD_LOCAL_NOTE) begin
        f = 1'b1;
      end else if (req_q.cmd == CMD_EVICT) begin
        if (req_q.token_count == '0 || req_q.is_transient) f = 1'b1;
      end else begin
        if (req_q.cmd == CMD_FETCH && req_q.is_transient) f = 1'b1;
        if (!f) begin
          known = hit;
          if (grp && !hit) begin
            if (!(|free_vec)) begin
              f = 1'b1;
            end else begin
              alloc = 1'b1;
              known = 1'b1;
            end
          end
        end
      end
      if (!f && grp && !req_q.is_transient && !known) f = 1'b1;
      if (!f) begin
        base_tok = alloc ? '0 : old_tok;
        new_tok  = (grp && !req_q.is_transient) ?
                   sat_add(base_tok, req_q.token_count) : base_tok;
        upd      = alloc || (grp && !req_q.is_transient);
        if (known) begin
          dest = DEST_LOWER;
        end else if (req_q.upper_has_room) begin
          dest = DEST_UPPER;
        end else begin
          dest = DEST_LOWER;
          oign = 1'b1;
        end
      end
    end

    if (f) begin
      dest = DEST_CONSUMED;
      oign = req_q.ignore_in;
      upd  = 1'b0;
    end

    sel     = alloc ? free_idx : hit_idx;
    new_row = rdata_q;
    new_row[sel*EW +: EW] = {new_valid, tag_q, new_tok};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      res_o.destination   <= dest;
      res_o.out_type      <= req_q.cmd;
      res_o.out_address   <= req_q.address;
      res_o.out_tokens    <= req_q.token_count;
      res_o.out_transient <= req_q.is_transient;
      res_o.out_source    <= req_q.source_cache;
      res_o.out_ignore    <= oign;
      res_o.fault         <= f;
    end
  end

endmodule

// File: design/token_coherence_directory.sv
`timescale 1ns / 1ps
// Set-associative token directory between an upper and a lower ring. A message is taken
// while the block is idle, which also reads its whole set row from the single-port directory
// memory into a register; once the result register is free, the block decides, writes the
// row back and loads the result register, from which the result is offered. The next message
// is taken only after that, so the block does not take a new message before it is through
// with the last one, and it waits longer while the result is still waiting to be taken.
// After reset the block clears the memory one set per cycle and takes no message until
// then; configuration writes are taken at any time. NUM_SETS must be a power of two,
// since the set index is the low bits of the line number.
module token_coherence_directory #(
  parameter int NUM_SETS   = 64,
  parameter int NUM_WAYS   = 16,
  parameter int TOKEN_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcd_msg_if.sink   msg_i,
  tcd_res_if.source res_o,
  tcd_cfg_if.sink   cfg_i
);
  import tcd_pkg::*;

  localparam int SET_IW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  ctrl_t             ctrl;
  logic [SET_IW-1:0] clr_addr;
  msg_t              msg;
  res_t              res;

  assign msg.cmd            = msg_i.cmd;
  assign msg.from_upper     = msg_i.from_upper;
  assign msg.address        = msg_i.address;
  assign msg.token_count    = msg_i.token_count;
  assign msg.is_transient   = msg_i.is_transient;
  assign msg.source_cache   = msg_i.source_cache;
  assign msg.ignore_in      = msg_i.ignore_in;
  assign msg.upper_has_room = msg_i.upper_has_room;

  assign cfg_i.ready = 1'b1;

  tcd_ctrl #(
    .NUM_SETS (NUM_SETS),
    .SET_IW   (SET_IW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (msg_i.valid),
    .in_ready_o  (msg_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .ctrl_o      (ctrl),
    .clr_addr_o  (clr_addr)
  );

  tcd_datapath #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .TOKEN_BITS (TOKEN_BITS),
    .SET_IW     (SET_IW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .clr_addr_i (clr_addr),
    .msg_i      (msg),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .res_o      (res)
  );

  assign res_o.destination   = res.destination;
  assign res_o.out_type      = res.out_type;
  assign res_o.out_address   = res.out_address;
  assign res_o.out_tokens    = res.out_tokens;
  assign res_o.out_transient = res.out_transient;
  assign res_o.out_source    = res.out_source;
  assign res_o.out_ignore    = res.out_ignore;
  assign res_o.fault         = res.fault;

  // A faulting message is always consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.fault |-> res_o.destination == DEST_CONSUMED)
    else $error("faulting result not consumed");

  // Only one message is in flight: no transfer in the cycle after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.valid && msg_i.ready |=> !msg_i.ready)
    else $error("message taken while another is in flight");

  // The memory clear and a message commit never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.clear && (ctrl.commit || ctrl.rd_en)))
    else $error("message handled during memory clear");

endmodule

// File: verif/tb_token_coherence_directory.sv
`timescale 1ns / 1ps
module tb_token_coherence_directory;
  import tcd_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 16;
  localparam int TOK_MAX = 255;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tcd_msg_if msg_if ();
  tcd_res_if res_if ();
  tcd_cfg_if cfg_if ();

  token_coherence_directory i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .msg_i (msg_if.sink),
    .res_o (res_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Directory copy used for prediction.
  bit          dir_valid [NSETS*NWAYS];
  bit [51:0]   dir_tag   [NSETS*NWAYS];
  int unsigned dir_tok   [NSETS*NWAYS];
  int unsigned grp_first = 0;
  int unsigned grp_count = 4;
  int unsigned line_log2 = 6;

  res_t expected_results[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   stall_long = 1'b0;
  int   stall_len = 0;
  int   rx_wait = 0;

  // Recently touched addresses, so that random traffic hits known lines.
  logic [63:0] hot_addr[$];

  function automatic bit src_in_group(int unsigned src);
    return src >= grp_first && (src - grp_first) < grp_count;
  endfunction

  function automatic int lookup_line(int unsigned set, logic [51:0] tag);
    for (int w = 0; w < NWAYS; w++) begin
      if (dir_valid[set*NWAYS+w] && dir_tag[set*NWAYS+w] == tag) return set*NWAYS + w;
    end
    return -1;
  endfunction

  function automatic int empty_way(int unsigned set);
    for (int w = 0; w < NWAYS; w++) begin
      if (!dir_valid[set*NWAYS+w]) return set*NWAYS + w;
    end
    return -1;
  endfunction

  function automatic int unsigned add_sat(int unsigned a, int unsigned b);
    return (a + b > TOK_MAX) ? TOK_MAX : a + b;
  endfunction

  function automatic res_t route_message(msg_t m);
    res_t r;
    logic [63:0] line;
    int unsigned set;
    logic [51:0] tag;
    int e;
    bit flt, below, alloc;
    logic [1:0] dest;
    logic oign;
    line = m.address >> line_log2;
    set = 32'(line % NSETS);
    tag = 52'(line / NSETS);
    flt = 1'b0;
    alloc = 1'b0;
    dest = DEST_CONSUMED;
    oign = m.ignore_in;
    if (!m.from_upper) begin
      if (m.ignore_in) begin
        dest = DEST_UPPER;
        oign = 1'b0;
      end else begin
        e = lookup_line(set, tag);
        if (m.cmd == CMD_LOCAL_NOTE) begin
          if (e < 0) flt = 1'b1;
          else begin
            dir_tok[e] = add_sat(dir_tok[e], m.token_count);
            oign = 1'b0;
          end
        end else begin
          if (m.cmd == CMD_FETCH && m.is_transient) flt = 1'b1;
          if (m.cmd == CMD_EVICT && (m.token_count == 0 || m.is_transient ||
              !src_in_group(m.source_cache))) flt = 1'b1;
          if (!flt && m.token_count > 0 && !m.is_transient && e < 0) flt = 1'b1;
          if (!flt) begin
            if (m.token_count > 0 && !m.is_transient) begin
              dir_tok[e] = (m.token_count >= dir_tok[e]) ? 0 : dir_tok[e] - m.token_count;
              if (dir_tok[e] == 0) dir_valid[e] = 1'b0;
            end
            dest = DEST_UPPER;
            oign = 1'b0;
          end
        end
      end
    end else begin
      below = src_in_group(m.source_cache);
      e = -1;
      if (m.cmd == CMD_LOCAL_NOTE) flt = 1'b1;
      else if (m.cmd == CMD_EVICT) begin
        if (m.token_count == 0 || m.is_transient) flt = 1'b1;
      end else begin
        if (m.cmd == CMD_FETCH && m.is_transient) flt = 1'b1;
        if (!flt) begin
          e = lookup_line(set, tag);
          if (below && e < 0) begin
            e = empty_way(set);
            if (e < 0) flt = 1'b1;
            else alloc = 1'b1;
          end
        end
      end
      if (!flt && below && !m.is_transient && e < 0) flt = 1'b1;
      if (!flt) begin
        if (alloc) begin
          dir_valid[e] = 1'b1;
          dir_tag[e] = tag;
          dir_tok[e] = 0;
        end
        if (below && !m.is_transient) dir_tok[e] = add_sat(dir_tok[e], m.token_count);
        if (e < 0) begin
          if (m.upper_has_room) dest = DEST_UPPER;
          else begin
            dest = DEST_LOWER;
            oign = 1'b1;
          end
        end else dest = DEST_LOWER;
      end
    end
    if (flt) begin
      dest = DEST_CONSUMED;
      oign = m.ignore_in;
    end
    r.destination = dest;
    r.out_type = m.cmd;
    r.out_address = m.address;
    r.out_tokens = m.token_count;
    r.out_transient = m.is_transient;
    r.out_source = m.source_cache;
    r.out_ignore = oign;
    r.fault = flt;
    return r;
  endfunction

  // Valid stays high after a transfer; the next call drops it only before a gap, wait_drained() always.
  task automatic send_message(msg_t m, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    msg_if.valid <= 1'b1;
    msg_if.cmd <= m.cmd;
    msg_if.from_upper <= m.from_upper;
    msg_if.address <= m.address;
    msg_if.token_count <= m.token_count;
    msg_if.is_transient <= m.is_transient;
    msg_if.source_cache <= m.source_cache;
    msg_if.ignore_in <= m.ignore_in;
    msg_if.upper_has_room <= m.upper_has_room;
    do @(posedge clk_i); while (!msg_if.ready);
    expected_results.push_back(route_message(m));
    hot_addr.push_back(m.address);
    if (hot_addr.size() > 24) void'(hot_addr.pop_front());
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_FIRST_CACHE: grp_first = val;
      CFG_GROUP_SIZE:  grp_count = val[4:0];
      default:         line_log2 = val[3:0];
    endcase
  endtask

  task automatic wait_drained();
    msg_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned first, int unsigned cnt, int unsigned lg);
    wait_drained();
    write_reg(CFG_FIRST_CACHE, 8'(first));
    write_reg(CFG_GROUP_SIZE, 8'(cnt));
    write_reg(CFG_LINE_LOG2, 8'(lg));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic msg_t make_msg(logic [1:0] cmd, bit up, logic [63:0] addr,
                                    int unsigned tok, bit tr, int unsigned src, bit ign,
                                    bit room);
    msg_t m;
    m.cmd = cmd;
    m.from_upper = up;
    m.address = addr;
    m.token_count = 8'(tok);
    m.is_transient = tr;
    m.source_cache = 8'(src);
    m.ignore_in = ign;
    m.upper_has_room = room;
    return m;
  endfunction

  function automatic int unsigned pick_src(bit in_grp);
    if (in_grp && grp_count != 0) return grp_first + $urandom_range(0, grp_count - 1) & 8'hFF;
    return $urandom_range(0, 255);
  endfunction

  function automatic msg_t random_message();
    msg_t m;
    logic [63:0] addr;
    int k;
    k = $urandom_range(0, 99);
    if (hot_addr.size() != 0 && k < 60) addr = hot_addr[$urandom_range(0, hot_addr.size() - 1)];
    else if (k < 85) addr = {$urandom(), $urandom()};
    else addr = {$urandom(), $urandom()} & ~(64'hFFFF_FFFF_FFFF_F000 << 0) ;
    m.cmd = 2'($urandom_range(0, 3));
    m.from_upper = 1'($urandom_range(0, 1));
    m.address = addr;
    m.token_count = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 2) != 0) m.token_count = 8'($urandom_range(1, 8));
    m.is_transient = ($urandom_range(0, 4) == 0);
    m.source_cache = 8'(pick_src($urandom_range(0, 3) != 0));
    m.ignore_in = ($urandom_range(0, 5) == 0);
    m.upper_has_room = 1'($urandom_range(0, 1));
    return m;
  endfunction

  // Reads and acquires from the group allocate lines; then tokens go up and back down.
  task automatic test_directed();
    logic [63:0] a;
    a = 64'h0000_0000_0000_1040;
    send_message(make_msg(CMD_FETCH, 1, a, 0, 0, 0, 0, 1));
    send_message(make_msg(CMD_ACQUIRE, 1, a, 255, 0, 1, 0, 1));
    send_message(make_msg(CMD_EVICT, 1, a, 200, 0, 2, 1, 0));
    send_message(make_msg(CMD_LOCAL_NOTE, 0, a, 255, 0, 3, 0, 0));
    send_message(make_msg(CMD_LOCAL_NOTE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 0));
    send_message(make_msg(CMD_LOCAL_NOTE, 1, a, 1, 0, 0, 1, 1));
    send_message(make_msg(CMD_FETCH, 1, a, 0, 1, 0, 0, 1));
    send_message(make_msg(CMD_FETCH, 0, a, 0, 1, 0, 0, 1));
    send_message(make_msg(CMD_EVICT, 1, a, 0, 0, 0, 0, 1));
    send_message(make_msg(CMD_EVICT, 1, a, 3, 1, 0, 0, 1));
    send_message(make_msg(CMD_EVICT, 0, a, 0, 0, 0, 0, 1));
    send_message(make_msg(CMD_EVICT, 0, a, 3, 0, 200, 0, 1));
    send_message(make_msg(CMD_EVICT, 0, a, 3, 1, 0, 0, 1));
    send_message(make_msg(CMD_EVICT, 1, 64'h8000_0000_0000_0000, 5, 0, 1, 0, 1));
    send_message(make_msg(CMD_ACQUIRE, 1, 64'h2000, 4, 0, 99, 0, 1));
    send_message(make_msg(CMD_ACQUIRE, 1, 64'h2000, 4, 0, 99, 1, 0));
    send_message(make_msg(CMD_ACQUIRE, 0, 64'h2000, 4, 0, 99, 1, 1));
    send_message(make_msg(CMD_ACQUIRE, 0, 64'h3000, 2, 0, 0, 0, 1));
    send_message(make_msg(CMD_FETCH, 0, a, 0, 0, 255, 0, 1));
    send_message(make_msg(CMD_EVICT, 0, a, 255, 0, 0, 0, 1));
    send_message(make_msg(CMD_ACQUIRE, 1, a, 5, 1, 0, 0, 1));
    send_message(make_msg(CMD_ACQUIRE, 0, a, 5, 1, 255, 0, 0));
  endtask

  // Eighteen distinct tags into one set overflow its sixteen ways.
  task automatic test_full_set();
    for (int i = 0; i < 18; i++) begin
      send_message(make_msg(CMD_ACQUIRE, 1, (64'(i + 100) * NSETS + 5) << line_log2, 1, 0,
                            pick_src(1), 0, 1));
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_message(random_message());
  endtask

  // The receiver stops while the sender keeps offering; then the sender waits for all.
  task automatic test_backpressure();
    stall_len = 150;
    stall_long = 1'b1;
    for (int i = 0; i < 12; i++) send_message(random_message(), 1'b1);
    wait_drained();
    test_random(20);
  endtask

  // After each result transfer the receiver holds off for a drawn number of cycles.
  always @(posedge clk_i) begin
    int rx_draw;
    if (stall_long) begin
      res_if.ready <= 1'b0;
      if (stall_len == 0) stall_long <= 1'b0;
      else stall_len <= stall_len - 1;
    end else if (res_if.valid && res_if.ready) begin
      rx_draw = $urandom_range(0, 13);
      rx_wait <= rx_draw;
      res_if.ready <= (rx_draw == 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait <= 0;
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.destination, res_if.out_type, res_if.out_address, res_if.out_tokens,
             res_if.out_transient, res_if.out_source, res_if.out_ignore, res_if.fault};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    msg_if.valid = 1'b0;
    msg_if.cmd = CMD_FETCH;
    msg_if.from_upper = 1'b0;
    msg_if.address = '0;
    msg_if.token_count = '0;
    msg_if.is_transient = 1'b0;
    msg_if.source_cache = '0;
    msg_if.ignore_in = 1'b0;
    msg_if.upper_has_room = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FIRST_CACHE;
    cfg_if.data = '0;
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      dir_valid[i] = 1'b0;
      dir_tag[i] = '0;
      dir_tok[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_set();
    test_random(300);
    test_backpressure();
    configure(250, 16, 2);
    test_directed();
    test_random(300);
    configure(0, 1, 10);
    test_full_set();
    test_random(250);
    configure(8'hFF, 0, 15);
    test_random(100);
    configure(16, 31, 4);
    test_random(300);
    configure(0, 4, 6);
    test_random(120);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
